[design/bldc_hall_six_step_commutator_unit_defines.svh]
// assertion macros shared by the commutator checker
`ifndef BLDC_HALL_SIX_STEP_COMMUTATOR_UNIT_DEFINES_SVH
`define BLDC_HALL_SIX_STEP_COMMUTATOR_UNIT_DEFINES_SVH

// same-cycle implication, disabled during reset
`define BHSC_ASSERT_NOW(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("commutator check failed");

// next-cycle implication, disabled during reset
`define BHSC_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("commutator check failed");

`endif

[design/bhsc_pkg.sv]
// types, codes and tables for the hall six-step commutator
`default_nettype none
package bhsc_pkg;

  // action codes of one input item
  localparam logic [2:0] ACT_EDGE    = 3'd0;
  localparam logic [2:0] ACT_UP      = 3'd1;
  localparam logic [2:0] ACT_DOWN    = 3'd2;
  localparam logic [2:0] ACT_STOP    = 3'd3;
  localparam logic [2:0] ACT_RESUME  = 3'd4;
  localparam logic [2:0] ACT_REVERSE = 3'd5;
  localparam logic [2:0] ACT_FORWARD = 3'd6;

  // register indexes
  localparam logic [1:0] REG_DUTY_STEP      = 2'd0;
  localparam logic [1:0] REG_DUTY_MAX       = 2'd1;
  localparam logic [1:0] REG_EDGES_PER_FLAG = 2'd2;

  // sector numbers used by the drive table
  localparam logic [2:0] SEC_1 = 3'd1;
  localparam logic [2:0] SEC_2 = 3'd2;
  localparam logic [2:0] SEC_3 = 3'd3;
  localparam logic [2:0] SEC_4 = 3'd4;
  localparam logic [2:0] SEC_5 = 3'd5;
  localparam logic [2:0] SEC_6 = 3'd6;
  localparam logic [2:0] SEC_NONE = 3'd0;

  // reset values
  localparam logic [8:0] DUTY_STEP_RST      = 9'd10;
  localparam logic [8:0] DUTY_MAX_RST       = 9'd290;
  localparam logic [7:0] EDGES_PER_FLAG_RST = 8'd100;
  localparam logic [8:0] DUTY_RST           = 9'd30;

  // gate drive of the three phases
  typedef struct packed {
    logic [8:0] high_a;
    logic [8:0] high_b;
    logic [8:0] high_c;
    logic       low_a;
    logic       low_b;
    logic       low_c;
  } gate_t;

  // forward-direction sector of a hall code, none for the two illegal codes
  function automatic logic [2:0] fwd_sector(input logic [2:0] code);
    logic [2:0] s;
    case (code)
      3'b010:  s = SEC_1;
      3'b011:  s = SEC_2;
      3'b001:  s = SEC_3;
      3'b101:  s = SEC_4;
      3'b100:  s = SEC_5;
      3'b110:  s = SEC_6;
      default: s = SEC_NONE;
    endcase
    return s;
  endfunction

endpackage
`default_nettype wire

[design/bhsc_gate_drive.sv]
// per-sector gate drive: one high side with duty, one low side on; all off while drive_on is low
`default_nettype none
module bhsc_gate_drive (
  input  wire logic [2:0]    sector,
  input  wire logic          drive_on,
  input  wire logic [8:0]    duty,
  output bhsc_pkg::gate_t    gates
);
  import bhsc_pkg::*;

  // select high and low phase by sector
  always_comb begin
    gates = '0;
    if (drive_on) begin
      case (sector)
        SEC_2: begin
          gates.high_a = duty;
          gates.low_c  = 1'b1;
        end
        SEC_3: begin
          gates.high_b = duty;
          gates.low_c  = 1'b1;
        end
        SEC_4: begin
          gates.high_b = duty;
          gates.low_a  = 1'b1;
        end
        SEC_5: begin
          gates.high_c = duty;
          gates.low_a  = 1'b1;
        end
        SEC_6: begin
          gates.high_c = duty;
          gates.low_b  = 1'b1;
        end
        default: begin
          gates.high_a = duty;
          gates.low_b  = 1'b1;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

[design/bldc_hall_six_step_commutator_unit.sv]
// top level of the hall six-step commutator with apb register port
// a result is registered and valid in the cycle after its item is accepted
// throughput: one item per cycle; in_ready drops only while the result register is held
// the whole update (hall table, duty clamp, edge count) sits before one result register
// reset (synchronous, active high) restores registers 10/290/100, sector 1, duty 30,
// forward direction, a cleared drive latch (the gate output registers are not reset), and empties the result register
`default_nettype none
module bldc_hall_six_step_commutator_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  // input channel
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  action,
  input  wire logic        hall_a,
  input  wire logic        hall_b,
  input  wire logic        hall_c,
  // result channel
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [8:0]       high_a_duty,
  output logic [8:0]       high_b_duty,
  output logic [8:0]       high_c_duty,
  output logic             low_a_on,
  output logic             low_b_on,
  output logic             low_c_on,
  output logic [2:0]       sector,
  output logic             rev_pulse,
  output logic [8:0]       duty_now,
  // configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import bhsc_pkg::*;

  // configuration registers
  logic [8:0] duty_step;
  logic [8:0] duty_max;
  logic [7:0] edges_per_flag;

  // block state
  logic [2:0] cur_sector, cur_sector_next;
  logic       reverse_dir, reverse_dir_next;
  logic [8:0] duty, duty_next;
  logic [8:0] saved_duty, saved_duty_next;
  logic [7:0] edge_count, edge_count_next;
  logic       drive_latched, drive_latched_next;
  logic [8:0] latched_duty, latched_duty_next;
  logic       pulse_next;

  logic       in_fire;
  logic       cfg_write;
  logic [1:0] reg_index;
  logic [2:0] fwd;
  logic [2:0] mapped;
  logic [7:0] count_inc;
  logic [9:0] duty_sum;
  gate_t      gates_next;

  assign pready    = 1'b1;
  assign reg_index = paddr[3:2];
  assign cfg_write = psel && penable && pwrite && pready;
  assign in_ready  = !out_valid || out_ready;
  assign in_fire   = in_valid && in_ready;

  // register write
  always_ff @(posedge clk) begin
    if (rst) begin
      duty_step      <= DUTY_STEP_RST;
      duty_max       <= DUTY_MAX_RST;
      edges_per_flag <= EDGES_PER_FLAG_RST;
    end else if (cfg_write) begin
      case (reg_index)
        REG_DUTY_STEP:      duty_step      <= pwdata[8:0];
        REG_DUTY_MAX:       duty_max       <= pwdata[8:0];
        REG_EDGES_PER_FLAG: edges_per_flag <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // register read
  always_comb begin
    case (reg_index)
      REG_DUTY_STEP:      prdata = {23'd0, duty_step};
      REG_DUTY_MAX:       prdata = {23'd0, duty_max};
      REG_EDGES_PER_FLAG: prdata = {24'd0, edges_per_flag};
      default:            prdata = '0;
    endcase
  end

  // hall code to sector, shifted by three in reverse
  assign fwd = fwd_sector({hall_a, hall_b, hall_c});
  always_comb begin
    if (!reverse_dir)      mapped = fwd;
    else if (fwd > SEC_3)  mapped = fwd - 3'd3;
    else                   mapped = fwd + 3'd3;
  end

  assign count_inc = edge_count + 8'd1;
  assign duty_sum  = {1'b0, duty} + {1'b0, duty_step};

  // next state for one item
  always_comb begin
    cur_sector_next    = cur_sector;
    reverse_dir_next   = reverse_dir;
    duty_next          = duty;
    saved_duty_next    = saved_duty;
    edge_count_next    = edge_count;
    drive_latched_next = drive_latched;
    latched_duty_next  = latched_duty;
    pulse_next         = 1'b0;
    case (action)
      ACT_EDGE: begin
        if (fwd != SEC_NONE) cur_sector_next = mapped;
        drive_latched_next = 1'b1;
        latched_duty_next  = duty;
        if (cur_sector_next == SEC_6) begin
          if (count_inc == edges_per_flag) begin
            pulse_next      = 1'b1;
            edge_count_next = '0;
          end else begin
            edge_count_next = count_inc;
          end
        end
      end
      ACT_UP: begin
        duty_next = (duty_sum > {1'b0, duty_max}) ? duty_max : duty_sum[8:0];
      end
      ACT_DOWN: begin
        duty_next = (duty_step > duty) ? 9'd0 : duty - duty_step;
      end
      ACT_STOP: begin
        saved_duty_next = duty;
        duty_next       = '0;
      end
      ACT_RESUME:  duty_next        = saved_duty;
      ACT_REVERSE: reverse_dir_next = 1'b1;
      ACT_FORWARD: reverse_dir_next = 1'b0;
      default: ;
    endcase
  end

  // gate pattern after this item
  bhsc_gate_drive u_gate_drive (
    .sector   (cur_sector_next),
    .drive_on (drive_latched_next),
    .duty     (latched_duty_next),
    .gates    (gates_next)
  );

  // state update
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_sector    <= SEC_1;
      reverse_dir   <= 1'b0;
      duty          <= DUTY_RST;
      saved_duty    <= '0;
      edge_count    <= '0;
      drive_latched <= 1'b0;
      latched_duty  <= '0;
    end else if (in_fire) begin
      cur_sector    <= cur_sector_next;
      reverse_dir   <= reverse_dir_next;
      duty          <= duty_next;
      saved_duty    <= saved_duty_next;
      edge_count    <= edge_count_next;
      drive_latched <= drive_latched_next;
      latched_duty  <= latched_duty_next;
    end
  end

  // result register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // result register payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      high_a_duty <= gates_next.high_a;
      high_b_duty <= gates_next.high_b;
      high_c_duty <= gates_next.high_c;
      low_a_on    <= gates_next.low_a;
      low_b_on    <= gates_next.low_b;
      low_c_on    <= gates_next.low_c;
      sector      <= cur_sector_next;
      rev_pulse   <= pulse_next;
      duty_now    <= duty_next;
    end
  end

endmodule
`default_nettype wire

[design/bhsc_checker.sv]
// port-level checks for the commutator, bound to the top level
`default_nettype none
`include "bldc_hall_six_step_commutator_unit_defines.svh"
module bhsc_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic        low_a_on,
  input wire logic        low_b_on,
  input wire logic        low_c_on,
  input wire logic [2:0]  sector,
  input wire logic        rev_pulse,
  input wire logic [8:0]  duty_now
);

  // a held result stays put
  `BHSC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(sector) && $stable(duty_now) && $stable(rev_pulse))

  // a stalled result register blocks new items
  `BHSC_ASSERT_NOW(a_stall_blocks_input, out_valid && !out_ready, !in_ready)

  // at most one low side switch on
  `BHSC_ASSERT_NOW(a_low_onehot, out_valid, $onehot0({low_a_on, low_b_on, low_c_on}))

  // reported sector is always a real sector
  `BHSC_ASSERT_NOW(a_sector_range, out_valid, sector >= 3'd1 && sector <= 3'd6)

  // the revolution pulse only comes from an edge item that lands in sector 6
  `BHSC_ASSERT_NOW(a_pulse_sector6, out_valid && rev_pulse, sector == 3'd6 && low_b_on)

endmodule

bind bldc_hall_six_step_commutator_unit bhsc_checker u_bhsc_checker (.*);
`default_nettype wire
